[hdl/lavm_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and arithmetic helpers for the look-at view matrix unit.
// Used by lavm_norm and look_at_view_matrix_unit; depends on nothing else.
package lavm_pkg;

   localparam int COORD_W = 32;                  // input coordinate width, Q16.16
   localparam int AXIS_W  = 32;                  // axis component width, Q2.30
   localparam int SHIFT_W = 32;                  // translation width, Q16.16
   localparam int FRAC    = 30;                  // fraction bits of a unit axis
   localparam int CMAG_W  = FRAC + 1;            // block-scaled magnitude width
   localparam int NVEC_W  = 66;                  // normalizer input width
   localparam int NMAG_W  = NVEC_W - 1;
   localparam int POS_W   = $clog2(NVEC_W);
   localparam int SIDE_W  = 3 * COORD_W + 3 * AXIS_W;
   localparam int PROD_W  = 2 * AXIS_W;
   localparam int AE_W    = AXIS_W + COORD_W;
   localparam int DOT_W   = AE_W + 2;

   localparam logic signed [AXIS_W-1:0] AXIS_ONE = AXIS_W'(1) << FRAC;

   typedef logic [2:0][COORD_W-1:0] coord_vec_type;
   typedef logic [2:0][AXIS_W-1:0]  axis_vec_type;
   typedef logic [2:0][NVEC_W-1:0]  nvec_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] eye_x;
      logic signed [COORD_W-1:0] eye_y;
      logic signed [COORD_W-1:0] eye_z;
      logic signed [COORD_W-1:0] target_x;
      logic signed [COORD_W-1:0] target_y;
      logic signed [COORD_W-1:0] target_z;
      logic signed [COORD_W-1:0] hint_up_x;
      logic signed [COORD_W-1:0] hint_up_y;
      logic signed [COORD_W-1:0] hint_up_z;
   } req_type;

   typedef struct packed {
      logic signed [AXIS_W-1:0]  right_x;
      logic signed [AXIS_W-1:0]  right_y;
      logic signed [AXIS_W-1:0]  right_z;
      logic signed [AXIS_W-1:0]  upward_x;
      logic signed [AXIS_W-1:0]  upward_y;
      logic signed [AXIS_W-1:0]  upward_z;
      logic signed [AXIS_W-1:0]  fwd_x;
      logic signed [AXIS_W-1:0]  fwd_y;
      logic signed [AXIS_W-1:0]  fwd_z;
      logic signed [SHIFT_W-1:0] shift_x;
      logic signed [SHIFT_W-1:0] shift_y;
      logic signed [SHIFT_W-1:0] shift_z;
   } rsp_type;

   function automatic logic [NMAG_W-1:0] mag_of(input logic [NVEC_W-1:0] v);
      logic [NVEC_W-1:0] n;
      n = ~v + NVEC_W'(1);
      return v[NVEC_W-1] ? n[NMAG_W-1:0] : v[NMAG_W-1:0];
   endfunction

   function automatic logic [NMAG_W-1:0] max3(input logic [2:0][NMAG_W-1:0] m);
      logic [NMAG_W-1:0] a;
      a = (m[0] > m[1]) ? m[0] : m[1];
      return (m[2] > a) ? m[2] : a;
   endfunction

   // Position of the leading one; zero for an all-zero word.
   function automatic logic [POS_W-1:0] msb_pos(input logic [NMAG_W-1:0] m);
      logic [POS_W-1:0] p;
      p = '0;
      for (int i = 0; i < NMAG_W; i++) begin
         if (m[i]) begin
            p = POS_W'(i);
         end
      end
      return p;
   endfunction

   // Moves a magnitude so that the largest one of its vector lands in [2^30, 2^31).
   function automatic logic [CMAG_W-1:0] scale_mag(input logic [NMAG_W-1:0] a,
                                                   input logic [POS_W-1:0]  p);
      logic [NMAG_W-1:0] t;
      if (p > POS_W'(FRAC)) begin
         t = a >> (p - POS_W'(FRAC));
      end else begin
         t = a << (POS_W'(FRAC) - p);
      end
      return t[CMAG_W-1:0];
   endfunction

   function automatic logic signed [PROD_W-1:0] mul_s(input logic signed [AXIS_W-1:0] a,
                                                      input logic signed [AXIS_W-1:0] b);
      return a * b;
   endfunction

   function automatic logic signed [AE_W-1:0] mul_ae(input logic signed [AXIS_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
      return a * b;
   endfunction

   function automatic logic signed [DOT_W-1:0] sum3(input logic [2:0][AE_W-1:0] p);
      logic signed [DOT_W-1:0] s;
      s = $signed(p[0]);
      s = s + $signed(p[1]);
      s = s + $signed(p[2]);
      return s;
   endfunction

   // Q4.60 to Q2.30 with round half up, clamped to plus or minus one.
   function automatic logic [AXIS_W-1:0] round_clamp_up(input logic signed [PROD_W-1:0] x);
      logic signed [PROD_W:0]      half;
      logic signed [PROD_W:0]      r;
      logic signed [PROD_W-FRAC:0] q;
      logic signed [PROD_W-FRAC:0] lim;
      logic signed [PROD_W-FRAC:0] nlim;
      half = '0;
      half[FRAC-1] = 1'b1;
      r = x + half;
      q = r[PROD_W:FRAC];
      lim = '0;
      lim[FRAC] = 1'b1;
      nlim = -lim;
      if (q > lim) begin
         return lim[AXIS_W-1:0];
      end else if (q < nlim) begin
         return nlim[AXIS_W-1:0];
      end
      return q[AXIS_W-1:0];
   endfunction

   // Negated, rounded Q20.46 dot product, saturated to a Q16.16 word.
   function automatic logic [SHIFT_W-1:0] neg_round_sat(input logic signed [DOT_W-1:0] s);
      logic signed [DOT_W:0]        half;
      logic signed [DOT_W:0]        r;
      logic signed [DOT_W-FRAC:0]   q;
      logic signed [DOT_W-FRAC+1:0] t;
      logic signed [DOT_W-FRAC+1:0] hi;
      logic signed [DOT_W-FRAC+1:0] lo;
      half = '0;
      half[FRAC-1] = 1'b1;
      r = s + half;
      q = r[DOT_W:FRAC];
      t = -q;
      hi = '0;
      hi[SHIFT_W-2:0] = '1;
      lo = '1;
      lo[SHIFT_W-2:0] = '0;
      if (t > hi) begin
         return hi[SHIFT_W-1:0];
      end else if (t < lo) begin
         return lo[SHIFT_W-1:0];
      end
      return t[SHIFT_W-1:0];
   endfunction

endpackage

[hdl/lavm_norm.sv]
`timescale 1ns / 1ps
// Pipelined 3-vector normalizer: block scaling, square sum, bit-serial root
// stages and restoring divide stages. Depends on lavm_pkg.
module lavm_norm (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  lavm_pkg::nvec_type           in_vec,
   input  logic [lavm_pkg::SIDE_W-1:0]  in_side,
   output logic                         out_valid,
   output lavm_pkg::axis_vec_type       out_vec,
   output logic [lavm_pkg::SIDE_W-1:0]  out_side
);
   import lavm_pkg::*;

   localparam int SUM_W    = 2 * CMAG_W + 2;
   localparam int ROOT_W   = SUM_W / 2;
   localparam int REM_W    = ROOT_W + 3;
   localparam int DEN_W    = ROOT_W;
   localparam int NUM_W    = CMAG_W + FRAC + 1;
   localparam int SQ_STEPS = ROOT_W;
   localparam int DV_STEPS = CMAG_W;
   localparam int ST_SUM   = 5;
   localparam int ST_SQ0   = ST_SUM + 1;
   localparam int ST_DVI   = ST_SQ0 + SQ_STEPS;
   localparam int ST_DV0   = ST_DVI + 1;
   localparam int ST_OUT   = ST_DV0 + DV_STEPS;
   localparam int N_ST     = ST_OUT + 1;

   logic                     v_ff    [0:N_ST-1];
   logic [SIDE_W-1:0]        side_ff [0:N_ST-1];
   logic [2:0]               neg_ff  [0:N_ST-1];
   logic [2:0][NMAG_W-1:0]   mag_ff  [0:2];
   logic [NMAG_W-1:0]        max_ff;
   logic [POS_W-1:0]         pos_ff;
   logic [2:0][CMAG_W-1:0]   cm_ff   [3:ST_DVI-1];
   logic [2:0][2*CMAG_W-1:0] sq_ff;
   logic [SUM_W-1:0]         xs_ff   [ST_SUM:ST_DVI-1];
   logic [REM_W-1:0]         srem_ff [ST_SUM:ST_DVI-1];
   logic [ROOT_W-1:0]        root_ff [ST_SUM:ST_DVI-1];
   logic [DEN_W-1:0]         den_ff  [ST_DVI:ST_OUT-1];
   logic [2:0][DEN_W-1:0]    drem_ff [ST_DVI:ST_OUT-1];
   logic [2:0][CMAG_W-1:0]   nlo_ff  [ST_DVI:ST_OUT-1];
   logic [2:0][CMAG_W-1:0]   quo_ff  [ST_DVI:ST_OUT-1];
   axis_vec_type             out_ff;

   logic [REM_W-1:0]         sqtr_in [ST_SQ0:ST_DVI-1];
   logic [REM_W-1:0]         sqtb_in [ST_SQ0:ST_DVI-1];
   logic [REM_W-1:0]         srem_in [ST_SQ0:ST_DVI-1];
   logic [ROOT_W-1:0]        root_in [ST_SQ0:ST_DVI-1];
   logic [2:0][NUM_W-1:0]    num_in;
   logic [2:0][DEN_W:0]      dvtr_in [ST_DV0:ST_OUT-1];
   logic [2:0][DEN_W-1:0]    drem_in [ST_DV0:ST_OUT-1];
   logic [2:0][CMAG_W-1:0]   quo_in  [ST_DV0:ST_OUT-1];

   // One root bit per stage: bring down two bits of the sum, try 4q+1.
   always_comb begin
      for (int k = ST_SQ0; k < ST_DVI; k++) begin
         sqtr_in[k] = {srem_ff[k-1][REM_W-3:0], xs_ff[k-1][SUM_W-1 -: 2]};
         sqtb_in[k] = {1'b0, root_ff[k-1], 2'b01};
         if (sqtr_in[k] >= sqtb_in[k]) begin
            srem_in[k] = sqtr_in[k] - sqtb_in[k];
            root_in[k] = {root_ff[k-1][ROOT_W-2:0], 1'b1};
         end else begin
            srem_in[k] = sqtr_in[k];
            root_in[k] = {root_ff[k-1][ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = NUM_W'({cm_ff[ST_DVI-1][i], FRAC'(0)})
                   + NUM_W'(root_ff[ST_DVI-1] >> 1);
      end
   end

   // One quotient bit per stage for each of the three components.
   always_comb begin
      for (int k = ST_DV0; k < ST_OUT; k++) begin
         for (int i = 0; i < 3; i++) begin
            dvtr_in[k][i] = {drem_ff[k-1][i], nlo_ff[k-1][i][CMAG_W-1]};
            if (dvtr_in[k][i] >= {1'b0, den_ff[k-1]}) begin
               drem_in[k][i] = DEN_W'(dvtr_in[k][i] - {1'b0, den_ff[k-1]});
               quo_in[k][i]  = {quo_ff[k-1][i][CMAG_W-2:0], 1'b1};
            end else begin
               drem_in[k][i] = dvtr_in[k][i][DEN_W-1:0];
               quo_in[k][i]  = {quo_ff[k-1][i][CMAG_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N_ST; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < N_ST; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int i = 0; i < 3; i++) begin
            neg_ff[0][i] <= in_vec[i][NVEC_W-1];
            mag_ff[0][i] <= mag_of(in_vec[i]);
         end
         for (int k = 1; k < N_ST; k++) begin
            side_ff[k] <= side_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
         end

         mag_ff[1] <= mag_ff[0];
         max_ff    <= max3(mag_ff[0]);
         mag_ff[2] <= mag_ff[1];
         pos_ff    <= msb_pos(max_ff);
         for (int i = 0; i < 3; i++) begin
            cm_ff[3][i] <= scale_mag(mag_ff[2][i], pos_ff);
            sq_ff[i]    <= cm_ff[3][i] * cm_ff[3][i];
         end
         for (int k = 4; k < ST_DVI; k++) begin
            cm_ff[k] <= cm_ff[k-1];
         end

         xs_ff[ST_SUM]   <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
         srem_ff[ST_SUM] <= '0;
         root_ff[ST_SUM] <= '0;
         for (int k = ST_SQ0; k < ST_DVI; k++) begin
            xs_ff[k]   <= xs_ff[k-1] << 2;
            srem_ff[k] <= srem_in[k];
            root_ff[k] <= root_in[k];
         end

         den_ff[ST_DVI] <= root_ff[ST_DVI-1];
         for (int i = 0; i < 3; i++) begin
            drem_ff[ST_DVI][i] <= DEN_W'(num_in[i][NUM_W-1:CMAG_W]);
            nlo_ff[ST_DVI][i]  <= num_in[i][CMAG_W-1:0];
            quo_ff[ST_DVI][i]  <= '0;
         end
         for (int k = ST_DV0; k < ST_OUT; k++) begin
            den_ff[k]  <= den_ff[k-1];
            drem_ff[k] <= drem_in[k];
            quo_ff[k]  <= quo_in[k];
            for (int i = 0; i < 3; i++) begin
               nlo_ff[k][i] <= nlo_ff[k-1][i] << 1;
            end
         end

         // A zero-length vector leaves a zero root; its axis is zero.
         for (int i = 0; i < 3; i++) begin
            if (den_ff[ST_OUT-1] == '0) begin
               out_ff[i] <= '0;
            end else if (neg_ff[ST_OUT-1][i]) begin
               out_ff[i] <= -AXIS_W'(quo_ff[ST_OUT-1][i]);
            end else begin
               out_ff[i] <= AXIS_W'(quo_ff[ST_OUT-1][i]);
            end
         end
      end
   end

   assign out_valid = v_ff[N_ST-1];
   assign out_vec   = out_ff;
   assign out_side  = side_ff[N_ST-1];

endmodule

[hdl/look_at_view_matrix_unit.sv]
`timescale 1ns / 1ps
// Throughput: one request per cycle while the skid register is free. The two
// normalizers are 71-stage pipelines (32 root stages and 31 divide stages
// each) and set the depth.
// A skid register behind the output register takes one more result while rsp stalls.
// Synchronous reset clears all valid bits; payload registers are not reset.
// Top level of the look-at view matrix unit; depends on lavm_pkg and lavm_norm.
module look_at_view_matrix_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lavm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lavm_pkg::rsp_type rsp_data
);
   import lavm_pkg::*;

   logic                       en;
   logic                       pv_ff [0:11];
   logic                       skid_v_ff;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_data_ff;
   rsp_type                    skid_ff;
   rsp_type                    res_in;

   coord_vec_type              eye_ff [0:11];
   logic [2:0][COORD_W:0]      dif_ff [0:4];
   coord_vec_type              hint0_ff;
   coord_vec_type              hmag_ff [1:3];
   logic [2:0]                 hneg_ff [1:3];
   logic [COORD_W-1:0]         hmax2_ff;
   logic [POS_W-1:0]           hpos3_ff;
   axis_vec_type               hs4_ff;
   axis_vec_type               fwd_ff [5:11];
   logic [5:0][PROD_W-1:0]     cp5_ff;
   logic [2:0][PROD_W-1:0]     rc6_ff;
   axis_vec_type               right_ff [7:11];
   logic [5:0][PROD_W-1:0]     up7_ff;
   logic [2:0][AE_W-1:0]       dr7_ff;
   logic [2:0][AE_W-1:0]       df7_ff;
   logic [2:0][PROD_W-1:0]     upc8_ff;
   logic signed [DOT_W-1:0]    sr_ff [8:11];
   logic signed [DOT_W-1:0]    sf_ff [8:11];
   axis_vec_type               upw_ff [9:11];
   logic [2:0][AE_W-1:0]       du10_ff;
   logic signed [DOT_W-1:0]    su11_ff;

   nvec_type                   n1_vec_in;
   nvec_type                   n2_vec_in;
   logic                       n1_valid;
   logic                       n2_valid;
   axis_vec_type               n1_fwd;
   axis_vec_type               n2_right;
   logic [SIDE_W-1:0]          n1_side;
   logic [SIDE_W-1:0]          n2_side;
   axis_vec_type               n1_hs;
   axis_vec_type               n2_fwd;
   coord_vec_type              n1_eye;
   coord_vec_type              n2_eye;

   // The pipeline moves whenever the skid register is free.
   assign en        = !skid_v_ff;
   assign req_ready = en;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n1_vec_in[i] = {{(NVEC_W-COORD_W-1){dif_ff[4][i][COORD_W]}}, dif_ff[4][i]};
         n2_vec_in[i] = {{(NVEC_W-PROD_W){rc6_ff[i][PROD_W-1]}}, rc6_ff[i]};
      end
   end

   lavm_norm u_norm_fwd (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pv_ff[4]),
      .in_vec    (n1_vec_in),
      .in_side   ({eye_ff[4], hs4_ff}),
      .out_valid (n1_valid),
      .out_vec   (n1_fwd),
      .out_side  (n1_side)
   );

   lavm_norm u_norm_right (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pv_ff[6]),
      .in_vec    (n2_vec_in),
      .in_side   ({eye_ff[6], fwd_ff[6]}),
      .out_valid (n2_valid),
      .out_vec   (n2_right),
      .out_side  (n2_side)
   );

   assign n1_eye = n1_side[SIDE_W-1 -: 3*COORD_W];
   assign n1_hs  = n1_side[3*AXIS_W-1:0];
   assign n2_eye = n2_side[SIDE_W-1 -: 3*COORD_W];
   assign n2_fwd = n2_side[3*AXIS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 12; k++) begin
            pv_ff[k] <= 1'b0;
         end
      end else if (en) begin
         pv_ff[0] <= req_valid;
         for (int k = 1; k < 5; k++) begin
            pv_ff[k] <= pv_ff[k-1];
         end
         pv_ff[5] <= n1_valid;
         pv_ff[6] <= pv_ff[5];
         pv_ff[7] <= n2_valid;
         for (int k = 8; k < 12; k++) begin
            pv_ff[k] <= pv_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         eye_ff[0] <= {req_data.eye_z, req_data.eye_y, req_data.eye_x};
         hint0_ff  <= {req_data.hint_up_z, req_data.hint_up_y, req_data.hint_up_x};
         dif_ff[0][0] <= {req_data.target_x[COORD_W-1], req_data.target_x}
                       - {req_data.eye_x[COORD_W-1], req_data.eye_x};
         dif_ff[0][1] <= {req_data.target_y[COORD_W-1], req_data.target_y}
                       - {req_data.eye_y[COORD_W-1], req_data.eye_y};
         dif_ff[0][2] <= {req_data.target_z[COORD_W-1], req_data.target_z}
                       - {req_data.eye_z[COORD_W-1], req_data.eye_z};
         for (int k = 1; k < 5; k++) begin
            eye_ff[k] <= eye_ff[k-1];
            dif_ff[k] <= dif_ff[k-1];
         end

         // Block scaling of the hint: magnitudes, largest, leading one, shift.
         for (int i = 0; i < 3; i++) begin
            hneg_ff[1][i] <= hint0_ff[i][COORD_W-1];
            hmag_ff[1][i] <= hint0_ff[i][COORD_W-1] ? -hint0_ff[i] : hint0_ff[i];
         end
         hmag_ff[2] <= hmag_ff[1];
         hneg_ff[2] <= hneg_ff[1];
         hmax2_ff   <= COORD_W'(max3({NMAG_W'(hmag_ff[1][2]), NMAG_W'(hmag_ff[1][1]),
                                      NMAG_W'(hmag_ff[1][0])}));
         hmag_ff[3] <= hmag_ff[2];
         hneg_ff[3] <= hneg_ff[2];
         hpos3_ff   <= msb_pos(NMAG_W'(hmax2_ff));
         for (int i = 0; i < 3; i++) begin
            if (hneg_ff[3][i]) begin
               hs4_ff[i] <= -AXIS_W'(scale_mag(NMAG_W'(hmag_ff[3][i]), hpos3_ff));
            end else begin
               hs4_ff[i] <= AXIS_W'(scale_mag(NMAG_W'(hmag_ff[3][i]), hpos3_ff));
            end
         end

         // Right before normalizing: scaled hint cross forward.
         eye_ff[5] <= n1_eye;
         fwd_ff[5] <= n1_fwd;
         cp5_ff[0] <= mul_s(n1_hs[1], n1_fwd[2]);
         cp5_ff[1] <= mul_s(n1_hs[2], n1_fwd[1]);
         cp5_ff[2] <= mul_s(n1_hs[2], n1_fwd[0]);
         cp5_ff[3] <= mul_s(n1_hs[0], n1_fwd[2]);
         cp5_ff[4] <= mul_s(n1_hs[0], n1_fwd[1]);
         cp5_ff[5] <= mul_s(n1_hs[1], n1_fwd[0]);
         eye_ff[6] <= eye_ff[5];
         fwd_ff[6] <= fwd_ff[5];
         rc6_ff[0] <= cp5_ff[0] - cp5_ff[1];
         rc6_ff[1] <= cp5_ff[2] - cp5_ff[3];
         rc6_ff[2] <= cp5_ff[4] - cp5_ff[5];

         // Up axis products and the eye dot products of right and forward.
         eye_ff[7]   <= n2_eye;
         fwd_ff[7]   <= n2_fwd;
         right_ff[7] <= n2_right;
         up7_ff[0]   <= mul_s(n2_fwd[1], n2_right[2]);
         up7_ff[1]   <= mul_s(n2_fwd[2], n2_right[1]);
         up7_ff[2]   <= mul_s(n2_fwd[2], n2_right[0]);
         up7_ff[3]   <= mul_s(n2_fwd[0], n2_right[2]);
         up7_ff[4]   <= mul_s(n2_fwd[0], n2_right[1]);
         up7_ff[5]   <= mul_s(n2_fwd[1], n2_right[0]);
         for (int i = 0; i < 3; i++) begin
            dr7_ff[i] <= mul_ae(n2_right[i], n2_eye[i]);
            df7_ff[i] <= mul_ae(n2_fwd[i], n2_eye[i]);
         end

         for (int k = 8; k < 12; k++) begin
            eye_ff[k]   <= eye_ff[k-1];
            fwd_ff[k]   <= fwd_ff[k-1];
            right_ff[k] <= right_ff[k-1];
         end
         upc8_ff[0] <= up7_ff[0] - up7_ff[1];
         upc8_ff[1] <= up7_ff[2] - up7_ff[3];
         upc8_ff[2] <= up7_ff[4] - up7_ff[5];
         sr_ff[8]   <= sum3(dr7_ff);
         sf_ff[8]   <= sum3(df7_ff);
         for (int k = 9; k < 12; k++) begin
            sr_ff[k] <= sr_ff[k-1];
            sf_ff[k] <= sf_ff[k-1];
         end
         for (int i = 0; i < 3; i++) begin
            upw_ff[9][i] <= round_clamp_up(upc8_ff[i]);
            du10_ff[i]   <= mul_ae(upw_ff[9][i], eye_ff[9][i]);
         end
         upw_ff[10] <= upw_ff[9];
         upw_ff[11] <= upw_ff[10];
         su11_ff    <= sum3(du10_ff);
      end
   end

   always_comb begin
      res_in.right_x  = right_ff[11][0];
      res_in.right_y  = right_ff[11][1];
      res_in.right_z  = right_ff[11][2];
      res_in.upward_x = upw_ff[11][0];
      res_in.upward_y = upw_ff[11][1];
      res_in.upward_z = upw_ff[11][2];
      res_in.fwd_x    = fwd_ff[11][0];
      res_in.fwd_y    = fwd_ff[11][1];
      res_in.fwd_z    = fwd_ff[11][2];
      res_in.shift_x  = neg_round_sat(sr_ff[11]);
      res_in.shift_y  = neg_round_sat(su11_ff);
      res_in.shift_z  = neg_round_sat(sf_ff[11]);
   end

   // A finished beat goes to the output register, or to the skid register when
   // the output still holds an untaken beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_v_ff    <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_ready) begin
            skid_v_ff <= 1'b0;
         end
      end else if (pv_ff[11]) begin
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (rsp_ready) begin
            rsp_data_ff <= skid_ff;
         end
      end else if (pv_ff[11]) begin
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_data_ff <= res_in;
         end else begin
            skid_ff <= res_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> rsp_valid_ff)
      else $error("skid register full while output register is empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (pv_ff[11] && rsp_valid_ff && !rsp_ready && !skid_v_ff) |=> skid_v_ff)
      else $error("finished beat not caught by skid register");

   a_fwd_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.fwd_x <= AXIS_ONE && rsp_data_ff.fwd_x >= -AXIS_ONE))
      else $error("forward component beyond one");

   a_up_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.upward_z <= AXIS_ONE && rsp_data_ff.upward_z >= -AXIS_ONE))
      else $error("up axis component beyond one");

endmodule

[sim/look_at_view_matrix_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for look_at_view_matrix_unit: directed and random view requests
// with fixed-point predictions of every axis and translation; uses lavm_pkg and the unit.
module look_at_view_matrix_unit_test;
   import lavm_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   typedef longint triple_type [3];
   typedef struct {
      req_type data;
      bit      drain;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    rsp_ready = 1'b0;
   req_type req_data = '0;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp_data;

   pending_type pending_q[$];
   rsp_type  view_q[$];
   int       errors = 0;
   int       beats_sent = 0;
   int       cycles = 0;

   look_at_view_matrix_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   function automatic bit [63:0] magn(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic void block_scale(input triple_type v, output triple_type o);
      bit [63:0] m, a;
      int rs, ls;
      m = 0; rs = 0; ls = 0;
      for (int i = 0; i < 3; i++) if (magn(v[i]) > m) m = magn(v[i]);
      if (m == 0) begin
         o[0] = 0; o[1] = 0; o[2] = 0;
         return;
      end
      while (m >= 64'd1 << 31) begin m = m >> 1; rs++; end
      while (m < 64'd1 << 30) begin m = m << 1; ls++; end
      for (int i = 0; i < 3; i++) begin
         a = (magn(v[i]) >> rs) << ls;
         o[i] = v[i] < 0 ? -longint'(a) : longint'(a);
      end
   endfunction

   function automatic bit [63:0] root_of(bit [63:0] x);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic void unit_vec(input triple_type v, output triple_type o);
      triple_type c;
      bit [63:0] sum, len, q;
      block_scale(v, c);
      sum = 0;
      for (int i = 0; i < 3; i++) sum += magn(c[i]) * magn(c[i]);
      if (sum == 0) begin
         o[0] = 0; o[1] = 0; o[2] = 0;
         return;
      end
      len = root_of(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((magn(c[i]) << 30) + (len >> 1)) / len;
         o[i] = c[i] < 0 ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic void cross3(input triple_type a, input triple_type b,
                                  output triple_type o);
      o[0] = a[1] * b[2] - a[2] * b[1];
      o[1] = a[2] * b[0] - a[0] * b[2];
      o[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function automatic logic [31:0] translation(triple_type ax, triple_type eye);
      longint hi, lo, eh, t;
      hi = 0; lo = 0;
      for (int i = 0; i < 3; i++) begin
         eh = eye[i] >>> 24;
         hi += ax[i] * eh;
         lo += ax[i] * (eye[i] - (eh <<< 24));
      end
      t = hi + (lo >>> 24);
      t = -((t + 32) >>> 6);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      return t[31:0];
   endfunction

   function automatic rsp_type view_of(req_type r);
      triple_type eye, diff, hint, hs, fwd, rc, right, upc, upw;
      longint u;
      rsp_type o;
      eye[0] = r.eye_x; eye[1] = r.eye_y; eye[2] = r.eye_z;
      diff[0] = longint'(r.target_x) - eye[0];
      diff[1] = longint'(r.target_y) - eye[1];
      diff[2] = longint'(r.target_z) - eye[2];
      hint[0] = r.hint_up_x; hint[1] = r.hint_up_y; hint[2] = r.hint_up_z;
      unit_vec(diff, fwd);
      block_scale(hint, hs);
      cross3(hs, fwd, rc);
      unit_vec(rc, right);
      cross3(fwd, right, upc);
      for (int i = 0; i < 3; i++) begin
         u = (upc[i] + (64'sd1 <<< 29)) >>> 30;
         if (u > (64'sd1 <<< 30)) u = 64'sd1 <<< 30;
         if (u < -(64'sd1 <<< 30)) u = -(64'sd1 <<< 30);
         upw[i] = u;
      end
      o.right_x = right[0][31:0]; o.right_y = right[1][31:0]; o.right_z = right[2][31:0];
      o.upward_x = upw[0][31:0]; o.upward_y = upw[1][31:0]; o.upward_z = upw[2][31:0];
      o.fwd_x = fwd[0][31:0]; o.fwd_y = fwd[1][31:0]; o.fwd_z = fwd[2][31:0];
      o.shift_x = translation(right, eye);
      o.shift_y = translation(upw, eye);
      o.shift_z = translation(fwd, eye);
      return o;
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report(string what, int field, logic [31:0] got, logic [31:0] want);
      $display("error: %s field %0d got %h expected %h", what, field, got, want);
      errors++;
   endtask

   // Sender: expectations are pushed here at acceptance so that the drain check sees them.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            view_q.push_back(view_of(req_data));
            beats_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_q.size() != 0 &&
                         !(pending_q[0].drain && (view_q.size() != 0 || req_valid))) begin
               req_data <= pending_q[0].data;
               pending_q.pop_front();
               req_valid <= 1'b1;
               send_gap = gap_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver, with one long hold-off once 300 requests have been accepted.
   int  recv_gap = 0;
   int  hold_left = 0;
   bit  hold_done = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && beats_sent >= 300) begin
         hold_done = 1;
         hold_left = 600;
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         recv_gap = gap_len();
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      logic [11:0][31:0] g, w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (view_q.size() == 0) begin
            report("unexpected beat", 0, rsp_data[31:0], 32'h0);
         end else begin
            want = view_q.pop_front();
            g = rsp_data;
            w = want;
            for (int i = 0; i < 12; i++)
               if (g[11 - i] !== w[11 - i]) report("result", i, g[11 - i], w[11 - i]);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("look_at_view_matrix_unit: mismatch");
         $finish;
      end
   end

   function automatic int rnd_coord();
      int v;
      v = $urandom;
      return v >>> $urandom_range(0, 31);
   endfunction

   task automatic add_view(int ex, int ey, int ez, int tx, int ty, int tz,
                           int hx, int hy, int hz, bit drain);
      pending_type p;
      p.data = '{ex, ey, ez, tx, ty, tz, hx, hy, hz};
      p.drain = drain;
      pending_q.push_back(p);
   endtask

   initial begin
      int ex, ey, ez, tx, ty, tz, hx, hy, hz, k;
      int maxc, minc, one;
      maxc = 32'h7fffffff; minc = 32'h80000000; one = 32'h10000;
      // Directed: plain camera, extremes, coincident eye and target, bad up hints.
      add_view(0, 0, 0, 0, 0, -one, 0, one, 0, 0);
      add_view(0, 0, 5 * one, 0, 0, 0, 0, one, 0, 0);
      add_view(one, 2 * one, 3 * one, one, 2 * one, 3 * one, 0, one, 0, 0);
      add_view(0, 0, 0, one, 0, 0, 0, 0, 0, 0);
      add_view(0, 0, 0, 0, one, 0, 0, 3 * one, 0, 0);
      add_view(0, 0, 0, 0, one, 0, 0, -one, 0, 0);
      add_view(maxc, maxc, maxc, minc, minc, minc, maxc, minc, maxc, 0);
      add_view(minc, minc, minc, maxc, maxc, maxc, minc, minc, minc, 0);
      add_view(minc, maxc, minc, maxc, minc, maxc, 1, 0, 0, 0);
      add_view(maxc, 0, minc, 0, 0, 0, 0, maxc, 0, 0);
      add_view(minc, minc, minc, minc, minc, minc, maxc, maxc, maxc, 0);
      add_view(0, 0, 0, 1, 0, 0, 0, 1, 0, 0);
      add_view(-1, -1, -1, 1, 1, 1, 1, -1, 1, 0);
      add_view(maxc, maxc, maxc, maxc - 1, maxc, maxc, minc, maxc, 0, 0);
      add_view(12345, -54321, 999, -7, 8, -9, 1, 1, 1, 0);
      for (int n = 0; n < 800; n++) begin
         k = $urandom_range(0, 99);
         ex = rnd_coord(); ey = rnd_coord(); ez = rnd_coord();
         tx = rnd_coord(); ty = rnd_coord(); tz = rnd_coord();
         hx = rnd_coord(); hy = rnd_coord(); hz = rnd_coord();
         if (k < 5) begin
            tx = ex; ty = ey; tz = ez;
         end else if (k < 10) begin
            hx = tx - ex; hy = ty - ey; hz = tz - ez;
         end else if (k < 13) begin
            hx = 0; hy = 0; hz = 0;
         end else if (k < 20) begin
            ex = $urandom; ey = $urandom; ez = $urandom;
            tx = $urandom; ty = $urandom; tz = $urandom;
         end
         add_view(ex, ey, ez, tx, ty, tz, hx, hy, hz, n == 550);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (pending_q.size() != 0 || req_valid) @(posedge clock);
      while (view_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("look_at_view_matrix_unit: match");
      end else begin
         $display("look_at_view_matrix_unit: mismatch");
      end
      $finish;
   end

endmodule
